// ===== src/base64_stream_decoder_macros.svh =====
// Assertion macros used by the checker in b64d_checker.sv.
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define B64D_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define B64D_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/b64d_pkg.sv =====
package b64d_pkg;

   // Character codes
   localparam logic [7:0] CHAR_PAD     = 8'h3D;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

   localparam logic [5:0] SYM_PLUS  = 6'd62;
   localparam logic [5:0] SYM_SLASH = 6'd63;
   localparam logic [7:0] LOWER_OFFSET = 8'd26;
   localparam logic [7:0] DIGIT_OFFSET = 8'd52;

   localparam logic [15:0] CAPACITY_RESET = 16'd32;

   typedef struct packed {
      logic [7:0] text_char;
      logic       end_of_message;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        byte_valid;
      logic [15:0] total_length;
      logic        message_done;
      logic        last_of_run;
   } rsp_payload_type;

   // One batch of results caused by a single character
   typedef struct packed {
      logic [23:0] bytes;       // decoded group, first byte in the top bits
      logic [1:0]  kept;        // bytes kept after the capacity check
      logic        report;      // a length report follows the bytes
      logic [15:0] first_total; // total shown on the first result
   } batch_type;

   // Map a character to its 6-bit symbol; anything outside the alphabet is 0
   function automatic logic [5:0] b64d_symbol(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         v = c - CHAR_UPPER_A;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         v = c - CHAR_LOWER_A + LOWER_OFFSET;
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         v = c - CHAR_DIGIT_0 + DIGIT_OFFSET;
      end else if (c == CHAR_PLUS) begin
         v = {2'b00, SYM_PLUS};
      end else if (c == CHAR_SLASH) begin
         v = {2'b00, SYM_SLASH};
      end
      return v[5:0];
   endfunction

endpackage

// ===== src/base64_stream_decoder.sv =====
// A result shows on rsp in the cycle after the character transfer that causes it.
// Throughput: one character per cycle; one result per cycle on rsp while rsp_ready is high, up to four per character.
// A character with results waits only while the output register still holds unsent results.
// Reset (synchronous, active high) clears the group, the byte count and the pending results in
// the output register, and sets the capacity to 32.
module base64_stream_decoder
   import b64d_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [15:0]     csr_data
);

   logic [15:0] capacity_ff, capacity_in;
   logic        buf_free;
   logic        load;
   batch_type   batch;

   // Take capacity writes at any time
   assign csr_ready   = 1'b1;
   assign capacity_in = (csr_valid && csr_ready) ? csr_data : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   b64d_group u_group (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .capacity  (capacity_ff),
      .buf_free  (buf_free),
      .load      (load),
      .batch     (batch)
   );

   b64d_drain u_drain (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .batch     (batch),
      .buf_free  (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/b64d_group.sv =====
module b64d_group
   import b64d_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   input  logic [15:0]     capacity,
   input  logic            buf_free,
   output logic            load,
   output batch_type       batch
);

   logic [23:0] bits_ff, bits_in;
   logic [1:0]  pos_ff, pos_in;
   logic [2:0]  pad_ff, pad_in;
   logic [15:0] count_ff, count_in;

   logic        eom;
   logic        skip;
   logic        is_pad;
   logic [5:0]  sym;
   logic [23:0] bits_step;
   logic [2:0]  pad_step;
   logic [2:0]  pos_step;
   logic        full;
   logic        flush;
   logic [23:0] flush_bits;
   logic [1:0]  offered;
   logic [15:0] avail;
   logic [1:0]  kept;
   logic        has_results;
   logic        accept;

   // Classify the character and shift it into the group
   always_comb begin
      eom    = req_data.end_of_message;
      skip   = (pos_ff == 2'd0) && (req_data.text_char == CHAR_LF ||
               req_data.text_char == CHAR_CR || req_data.text_char == CHAR_SPACE);
      is_pad = (req_data.text_char == CHAR_PAD);
      sym    = b64d_symbol(req_data.text_char);
      if (skip) begin
         bits_step = bits_ff;
         pad_step  = pad_ff;
         pos_step  = {1'b0, pos_ff};
      end else begin
         bits_step = {bits_ff[17:0], sym};
         pad_step  = pad_ff + {2'b00, is_pad};
         pos_step  = {1'b0, pos_ff} + 3'd1;
      end
   end

   // Decide on a flush and left-align a short final group
   always_comb begin
      full  = (pos_step == 3'd4);
      flush = full || (eom && pos_step != 3'd0);
      unique case (pos_step[1:0])
         2'd1:    flush_bits = {bits_step[5:0], 18'd0};
         2'd2:    flush_bits = {bits_step[11:0], 12'd0};
         2'd3:    flush_bits = {bits_step[17:0], 6'd0};
         default: flush_bits = bits_step;
      endcase
   end

   // Count the bytes offered and those the capacity still admits
   always_comb begin
      priority if (pad_step >= 3'd2) begin
         offered = 2'd1;
      end else if (pad_step == 3'd1) begin
         offered = 2'd2;
      end else begin
         offered = 2'd3;
      end
      avail = (count_ff < capacity) ? (capacity - count_ff) : 16'd0;
      if (!flush) begin
         kept = 2'd0;
      end else if (avail < {14'd0, offered}) begin
         kept = avail[1:0];
      end else begin
         kept = offered;
      end
      has_results = (kept != 2'd0) || eom;
   end

   // Hold off only an item with results while the output side is busy
   assign req_ready = buf_free || !has_results;
   assign accept    = req_valid && req_ready;
   assign load      = accept && has_results;

   always_comb begin
      batch.bytes       = flush_bits;
      batch.kept        = kept;
      batch.report      = eom;
      batch.first_total = (kept != 2'd0) ? (count_ff + 16'd1) : count_ff;
   end

   // Advance the group state on each transfer
   always_comb begin
      bits_in  = bits_ff;
      pos_in   = pos_ff;
      pad_in   = pad_ff;
      count_in = count_ff;
      if (accept) begin
         count_in = eom ? 16'd0 : (count_ff + {14'd0, kept});
         if (flush || eom) begin
            bits_in = 24'd0;
            pos_in  = 2'd0;
            pad_in  = 3'd0;
         end else begin
            bits_in = bits_step;
            pos_in  = pos_step[1:0];
            pad_in  = pad_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff  <= 24'd0;
         pos_ff   <= 2'd0;
         pad_ff   <= 3'd0;
         count_ff <= 16'd0;
      end else begin
         bits_ff  <= bits_in;
         pos_ff   <= pos_in;
         pad_ff   <= pad_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== src/b64d_drain.sv =====
module b64d_drain
   import b64d_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  batch_type       batch,
   output logic            buf_free,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   logic [1:0]  rem_ff, rem_in;
   logic        report_ff, report_in;
   logic [23:0] bytes_ff, bytes_in;
   logic [15:0] total_ff, total_in;

   logic        is_byte;
   logic        last;
   logic        xfer;

   // Show the current result from the batch registers
   always_comb begin
      is_byte   = (rem_ff != 2'd0);
      last      = is_byte ? (rem_ff == 2'd1 && !report_ff) : 1'b1;
      rsp_valid = is_byte || report_ff;
      xfer      = rsp_valid && rsp_ready;
      buf_free  = !rsp_valid || (xfer && last);

      rsp_data.data_byte    = is_byte ? bytes_ff[23:16] : 8'd0;
      rsp_data.byte_valid   = is_byte;
      rsp_data.total_length = total_ff;
      rsp_data.message_done = !is_byte;
      rsp_data.last_of_run  = last;
   end

   // Load a new batch, or step through the current one on each transfer
   always_comb begin
      rem_in    = rem_ff;
      report_in = report_ff;
      bytes_in  = bytes_ff;
      total_in  = total_ff;
      if (load) begin
         rem_in    = batch.kept;
         report_in = batch.report;
         bytes_in  = batch.bytes;
         total_in  = batch.first_total;
      end else if (xfer) begin
         if (is_byte) begin
            rem_in   = rem_ff - 2'd1;
            bytes_in = {bytes_ff[15:0], 8'd0};
            total_in = (rem_ff == 2'd1) ? total_ff : (total_ff + 16'd1);
         end else begin
            report_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff    <= 2'd0;
         report_ff <= 1'b0;
      end else begin
         rem_ff    <= rem_in;
         report_ff <= report_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      total_ff <= total_in;
   end

endmodule

// ===== src/b64d_checker.sv =====
`include "base64_stream_decoder_macros.svh"

module b64d_checker
   import b64d_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   logic rsp_xfer;
   logic done_xfer;

   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign done_xfer = rsp_xfer && rsp_data.message_done;

   // A stalled result holds
   `B64D_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   // The length report is never a byte and always closes its run
   `B64D_ASSERT(a_report_form, clock, reset, rsp_valid && rsp_data.message_done |-> !rsp_data.byte_valid && rsp_data.last_of_run, "malformed length report")

   // A kept byte always counts itself
   `B64D_ASSERT(a_byte_total, clock, reset, rsp_valid && rsp_data.byte_valid |-> rsp_data.total_length != 16'd0, "byte with zero total")

   // A byte right after a report starts a new message count
   `B64D_ASSERT(a_count_restart, clock, reset, done_xfer |=> !(rsp_valid && rsp_data.byte_valid) || rsp_data.total_length == 16'd1, "count did not restart")

   // Nothing is offered right after reset
   `B64D_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind base64_stream_decoder b64d_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/b64d_decode_checker.sv =====
module b64d_decode_checker
   import b64d_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_data,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_data,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  logic [15:0]     csr_data,
   output int              mismatches,
   output int              outstanding
);

   // Decoded bytes and length reports still owed by the block, oldest first
   rsp_payload_type decoded_results[$];
   rsp_payload_type char_results[$];
   rsp_payload_type got_result;
   rsp_payload_type want_result;

   // Predicted decoder state
   logic [15:0] capacity;
   logic [23:0] group_bits;
   logic [2:0]  group_pos;
   logic [2:0]  pad_seen;
   logic [15:0] kept_count;
   int          error_total = 0;

   task automatic log_error(input string text);
      $display("%0t: %s", $time, text);
      error_total++;
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want) begin
         log_error($sformatf("%s: got %0h, expected %0h", name, got, want));
      end
   endtask

   // Six-bit value of one text character; '=' and foreign characters give 0
   function automatic logic [5:0] char_to_symbol(input logic [7:0] c);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return 6'(c - CHAR_UPPER_A);
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return 6'(c - CHAR_LOWER_A + 8'd26);
      if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) return 6'(c - CHAR_DIGIT_0 + 8'd52);
      if (c == CHAR_PLUS) return 6'd62;
      if (c == CHAR_SLASH) return 6'd63;
      return 6'd0;
   endfunction

   // Keep one byte while the message is under capacity, else drop it
   task automatic keep_byte(input logic [7:0] value);
      rsp_payload_type r;
      if (kept_count < capacity) begin
         kept_count = kept_count + 16'd1;
         r = '{data_byte: value, byte_valid: 1'b1, total_length: kept_count,
               message_done: 1'b0, last_of_run: 1'b0};
         char_results.push_back(r);
      end
   endtask

   // Emit the bytes of a finished group and start a new one
   task automatic close_group();
      keep_byte(group_bits[23:16]);
      if (pad_seen < 3'd2) keep_byte(group_bits[15:8]);
      if (pad_seen < 3'd1) keep_byte(group_bits[7:0]);
      group_bits = '0;
      group_pos  = '0;
      pad_seen   = '0;
   endtask

   // Work out every result one accepted character causes
   task automatic predict_decode(input req_payload_type item);
      rsp_payload_type r;
      logic [5:0]      sym;
      logic            skipped;
      char_results.delete();
      skipped = (group_pos == 3'd0) &&
                (item.text_char == CHAR_LF || item.text_char == CHAR_CR ||
                 item.text_char == CHAR_SPACE);
      if (!skipped) begin
         if (item.text_char == CHAR_PAD) begin
            sym      = 6'd0;
            pad_seen = pad_seen + 3'd1;
         end else begin
            sym = char_to_symbol(item.text_char);
         end
         group_bits = {group_bits[17:0], sym};
         group_pos  = group_pos + 3'd1;
         if (group_pos == 3'd4) close_group();
      end
      if (item.end_of_message) begin
         // pad a short group with zero symbols, then report the length
         if (group_pos != 3'd0) begin
            group_bits = group_bits << (6 * (4 - int'(group_pos)));
            close_group();
         end
         r = '{data_byte: 8'h00, byte_valid: 1'b0, total_length: kept_count,
               message_done: 1'b1, last_of_run: 1'b0};
         char_results.push_back(r);
         kept_count = '0;
      end
      if (char_results.size() > 0) begin
         r = char_results.pop_back();
         r.last_of_run = 1'b1;
         char_results.push_back(r);
      end
      foreach (char_results[i]) decoded_results.push_back(char_results[i]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         capacity   = CAPACITY_RESET;
         group_bits = '0;
         group_pos  = '0;
         pad_seen   = '0;
         kept_count = '0;
         decoded_results.delete();
      end else begin
         // Compare each result transfer with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            got_result = rsp_data;
            if (decoded_results.size() == 0) begin
               log_error($sformatf("unexpected result %h", got_result));
            end else begin
               want_result = decoded_results.pop_front();
               check_field("data_byte", got_result.data_byte, want_result.data_byte);
               check_field("byte_valid", got_result.byte_valid, want_result.byte_valid);
               check_field("total_length", got_result.total_length,
                           want_result.total_length);
               check_field("message_done", got_result.message_done,
                           want_result.message_done);
               check_field("last_of_run", got_result.last_of_run,
                           want_result.last_of_run);
            end
         end
         // A character taken at the same edge as a write still sees the old capacity
         if (req_valid && req_ready) predict_decode(req_data);
         if (csr_valid && csr_ready) capacity = csr_data;
      end
      mismatches  <= error_total;
      outstanding <= decoded_results.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
   import b64d_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_CHARS    = 25;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;
   logic            csr_valid;
   logic            csr_ready;
   logic [15:0]     csr_data;

   int mismatches;
   int outstanding;
   int chars_sent  = 0;
   int idle_cycles = 0;
   int stall_draw;
   int hold_left;
   bit calm = 1'b0;

   base64_stream_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   b64d_decode_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall the result side for a random count after each transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (!rsp_ready) begin
         if (hold_left == 0) rsp_ready <= 1'b1;
         else hold_left <= hold_left - 1;
      end else if (rsp_valid) begin
         stall_draw = calm ? 0 : $urandom_range(0, 10);
         if (stall_draw != 0) begin
            rsp_ready <= 1'b0;
            hold_left <= stall_draw - 1;
         end
      end
   end

   // End the run when no transfer of any kind happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one character after a random gap and hold it until the transfer
   task automatic send_char(input logic [7:0] c, input logic eom);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{text_char: c, end_of_message: eom};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_text(input string s, input bit eom_last);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], eom_last && (i == s.len() - 1));
      end
   endtask

   // Wait until every predicted result has gone out, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] symbol_char(input int idx);
      if (idx < 26) return CHAR_UPPER_A + 8'(idx);
      if (idx < 52) return CHAR_LOWER_A + 8'(idx - 26);
      if (idx < 62) return CHAR_DIGIT_0 + 8'(idx - 52);
      if (idx == 62) return CHAR_PLUS;
      return CHAR_SLASH;
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 2))
         0: return CHAR_LF;
         1: return CHAR_CR;
         default: return CHAR_SPACE;
      endcase
   endfunction

   // Build a mostly well-formed message with random content, then send it
   task automatic send_message();
      logic [7:0] text_q[$];
      int         groups;
      int         pads;
      int         cut;
      int         pick;
      groups = $urandom_range(1, 4);
      for (int g = 0; g < groups; g++) begin
         if ($urandom_range(0, 3) == 0) text_q.push_back(blank_char());
         for (int j = 0; j < 4; j++) text_q.push_back(symbol_char($urandom_range(0, 63)));
      end
      pick = $urandom_range(0, 9);
      pads = (pick < 6) ? 0 : (pick < 8) ? 1 : (pick == 8) ? 2 : $urandom_range(3, 4);
      for (int j = 0; j < pads; j++) text_q[text_q.size() - 1 - j] = CHAR_PAD;
      // corrupt one character now and then
      if ($urandom_range(0, 3) == 0) begin
         text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
      end
      // cut the last group short now and then
      if ($urandom_range(0, 4) == 0) begin
         cut = $urandom_range(1, 3);
         repeat (cut) void'(text_q.pop_back());
      end
      if ($urandom_range(0, 5) == 0) text_q.push_back(blank_char());
      foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
         send_char(8'($urandom_range(0, 255)), (i == n - 1) || ($urandom_range(0, 7) == 0));
      end
   endtask

   initial begin
      logic [15:0] capacity_plan[6];
      int          phase_end;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: skipped blanks, padding, alphabet ends, foreign codes, short groups
      send_text(" \n\rTWFu", 1'b0);
      send_text("QUI=", 1'b0);
      send_text("====", 1'b0);
      send_text("\r", 1'b1);
      send_char(8'hFF, 1'b0);
      send_char(8'h00, 1'b0);
      send_char(CHAR_SPACE, 1'b0);
      send_char(CHAR_PAD, 1'b0);
      send_text("+/9z", 1'b0);
      send_text("Az", 1'b1);
      send_char(CHAR_LF, 1'b1);

      // Random phases over several capacities, extremes included
      capacity_plan = '{16'd0, 16'hFFFF, 16'd1, 16'd7, CAPACITY_RESET,
                        16'($urandom_range(2, 40))};
      for (int p = 0; p < 6; p++) begin
         write_capacity(capacity_plan[p]);
         calm = (p % 3 == 2);
         phase_end = chars_sent + PHASE_CHARS;
         while (chars_sent < phase_end) begin
            if ($urandom_range(0, 7) == 0) send_noise();
            else send_message();
         end
      end
      calm = 1'b0;

      drain();
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/b64d_pkg.sv
src/b64d_group.sv
src/b64d_drain.sv
src/base64_stream_decoder.sv
src/b64d_checker.sv
tb/sv/b64d_decode_checker.sv
tb/sv/tb.sv
